// File: design/stjq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stjq_pkg
// Shared types and codes of the stepper job queue controller.
// ---------------------------------------------------------------------------
package stjq_pkg;

  // Command codes carried by the cmd field of an input item.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_ENQUEUE = 1'b1;

  // One queued move job.
  typedef struct packed {
    logic [31:0] goal;
    logic [31:0] interval;
    logic [7:0]  tag;
  } job_entry_t;

endpackage
`default_nettype wire

// File: design/stepper_job_queue_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stepper_job_queue_controller_core
// Move-job FIFO and step sequencer for one stepper motor.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per accepted edge:
//   cmd selects an enqueue of a move job (goal_position, step_interval_us,
//   job_tag) or a timer tick carrying now_us. Every input item yields exactly
//   one result item on the output channel (out_valid / out_stall): the step
//   pulse and direction, the position after the item, busy, job done with
//   its tag, and an enqueue reject flag.
//   The result is registered: it is loaded into the output register at the
//   accepting edge and is offered in the cycle after it. Throughput is one
//   item per cycle while the receiver does not stall; the whole update is
//   one pass of compare and add logic between the input ports and the
//   output register, and the job queue memory is read one entry ahead
//   (the entry at the next head) so the head job is always in a register.
//   When the receiver stalls, the result holds in the output register and
//   in_stall rises in the same cycle; items flow again once it is taken.
//   Reset (rst, synchronous) empties the queue, clears the active job,
//   busy and position, and drops any pending result. Queue entries are not
//   cleared; an entry is only used after it has been written.
// ---------------------------------------------------------------------------
module stepper_job_queue_controller_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cmd,
  input  wire logic [31:0]        now_us,
  input  wire logic signed [31:0] goal_position,
  input  wire logic [31:0]        step_interval_us,
  input  wire logic [7:0]         job_tag,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    step_pulse,
  output logic                    step_dir,
  output logic signed [31:0]      position,
  output logic                    busy_res,
  output logic                    job_done,
  output logic [7:0]              done_tag,
  output logic                    enqueue_rejected
);
  import stjq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Job queue storage and the prefetched head entry.
  job_entry_t job_mem [QUEUE_DEPTH];
  job_entry_t head_entry;
  job_entry_t wr_entry;

  // Controller state.
  logic [31:0]      motor_pos;
  logic             busy;
  logic             active;
  logic [31:0]      act_goal;
  logic [31:0]      act_interval;
  logic [7:0]       act_tag;
  logic [31:0]      stamp_us;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  logic [31:0]      motor_pos_next;
  logic             busy_next;
  logic             active_next;
  logic [31:0]      act_goal_next;
  logic [31:0]      act_interval_next;
  logic [7:0]       act_tag_next;
  logic [31:0]      stamp_us_next;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic [CNT_W-1:0] count_next;

  logic             accept;
  logic             wr_en;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;
  logic [31:0]      sel_goal;
  logic             step_fwd;
  logic [31:0]      pos_stepped;
  logic [31:0]      due_time;

  logic             pulse_c;
  logic             dir_c;
  logic             done_c;
  logic [7:0]       dtag_c;
  logic             rej_c;

  // Take a new item unless a finished result is still waiting.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign head_inc = (head == PTR_LAST) ? '0 : head + PTR_W'(1);
  assign tail_inc = (tail == PTR_LAST) ? '0 : tail + PTR_W'(1);

  assign wr_entry = '{goal: goal_position, interval: step_interval_us, tag: job_tag};

  // Step toward the job being started, or toward the running job.
  assign sel_goal    = active ? act_goal : head_entry.goal;
  assign step_fwd    = !($signed(sel_goal) < $signed(motor_pos));
  assign pos_stepped = step_fwd ? motor_pos + 32'd1 : motor_pos - 32'd1;

  // Next step is due once now passes last step + interval, wrapping sum.
  assign due_time = stamp_us + act_interval;

  always_comb begin
    motor_pos_next    = motor_pos;
    busy_next         = busy;
    active_next       = active;
    act_goal_next     = act_goal;
    act_interval_next = act_interval;
    act_tag_next      = act_tag;
    stamp_us_next     = stamp_us;
    head_next         = head;
    tail_next         = tail;
    count_next        = count;
    wr_en             = 1'b0;
    pulse_c           = 1'b0;
    dir_c             = 1'b0;
    done_c            = 1'b0;
    dtag_c            = '0;
    rej_c             = 1'b0;

    if (accept) begin
      if (cmd == CMD_ENQUEUE) begin
        if (count == CNT_FULL) begin
          // drop the job, leave busy as is
          rej_c = 1'b1;
        end else begin
          wr_en      = 1'b1;
          tail_next  = tail_inc;
          count_next = count + CNT_W'(1);
          busy_next  = 1'b1;
        end
      end else if (!active) begin
        if (count == '0) begin
          busy_next = 1'b0;
        end else begin
          // pop the head job and take at most one start step
          act_goal_next     = head_entry.goal;
          act_interval_next = head_entry.interval;
          act_tag_next      = head_entry.tag;
          head_next         = head_inc;
          count_next        = count - CNT_W'(1);
          active_next       = 1'b1;
          stamp_us_next     = now_us;
          if (head_entry.goal != motor_pos) begin
            pulse_c        = 1'b1;
            dir_c          = step_fwd;
            motor_pos_next = pos_stepped;
          end
          if (head_entry.goal == motor_pos_next) begin
            // start step reached the goal: retire in the same item
            active_next = 1'b0;
            done_c      = 1'b1;
            dtag_c      = head_entry.tag;
            if (count_next == '0) begin
              busy_next = 1'b0;
            end
          end
        end
      end else if (act_goal == motor_pos) begin
        // retire the running job
        active_next = 1'b0;
        done_c      = 1'b1;
        dtag_c      = act_tag;
        if (count == '0) begin
          busy_next = 1'b0;
        end
      end else if (now_us > due_time) begin
        pulse_c        = 1'b1;
        dir_c          = step_fwd;
        motor_pos_next = pos_stepped;
        stamp_us_next  = now_us;
      end
    end
  end

  // Queue memory: write at tail, read the entry at the next head. Forward
  // the write when it lands on that entry (enqueue into an empty queue).
  always_ff @(posedge clk) begin
    if (wr_en) begin
      job_mem[tail] <= wr_entry;
    end
    if (wr_en && (tail == head_next)) begin
      head_entry <= wr_entry;
    end else begin
      head_entry <= job_mem[head_next];
    end
  end

  // Controller state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_pos    <= '0;
      busy         <= 1'b0;
      active       <= 1'b0;
      act_goal     <= '0;
      act_interval <= '0;
      act_tag      <= '0;
      stamp_us     <= '0;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
    end else begin
      motor_pos    <= motor_pos_next;
      busy         <= busy_next;
      active       <= active_next;
      act_goal     <= act_goal_next;
      act_interval <= act_interval_next;
      act_tag      <= act_tag_next;
      stamp_us     <= stamp_us_next;
      head         <= head_next;
      tail         <= tail_next;
      count        <= count_next;
    end
  end

  // Output register: load on accept, hold while stalled, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step_pulse       <= pulse_c;
      step_dir         <= dir_c;
      position         <= motor_pos_next;
      busy_res         <= busy_next;
      job_done         <= done_c;
      done_tag         <= dtag_c;
      enqueue_rejected <= rej_c;
    end
  end

endmodule
`default_nettype wire
